@@ design/ddo_pkg.sv @@
`timescale 1ns / 1ps

package ddo_pkg;

	localparam int unsigned LIMB_W       = 32;
	localparam int unsigned ACC_LIMBS    = 4;
	localparam int unsigned ACC_W        = LIMB_W * ACC_LIMBS;
	// widest dividend is below 2^100, so the quotient needs only that many steps
	localparam int unsigned DIV_STEPS    = 100;
	localparam int unsigned DIV_PRESHIFT = ACC_W - DIV_STEPS;

	localparam logic [31:0] MS_PER_S          = 32'd1000;
	localparam logic [31:0] RST_DIST_PER_TICK = 32'd658844;
	localparam logic [23:0] RST_INV_HALF_BASE = 24'd1170286;

	localparam logic CFG_DIST_PER_TICK = 1'b0;
	localparam logic CFG_INV_HALF_BASE = 1'b1;

	typedef enum logic {
		ALU_MAC,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t     op;
		logic [32:0] a;
		logic [31:0] b;
		logic [31:0] c;
	} alu_req_t;

	typedef struct packed {
		logic [63:0] res;
	} alu_rsp_t;

	typedef struct packed {
		logic [ACC_W-1:0] acc;
		logic             sh_long;
		logic             neg;
		logic             is_unsigned;
	} sat_req_t;

	typedef struct packed {
		logic [31:0] value;
		logic        over;
	} sat_rsp_t;

endpackage

@@ design/diff_drive_odometry_unit.sv @@
// channel  dir  handshake           payload
// s        in   s_tvalid/s_tready   s_tdata: right_count, left_count, time_ms
// m        out  m_tvalid/m_tready   m_tdata: deltas, distance, speed, turn_rate
//                                   m_tuser: time_zero, saturated
// cfg      in   cfg_we              cfg_addr, cfg_wdata
//
// one sample passes delta, sum and accumulate, then a load and limb-serial multiply
// per job (distance, speed, turn rate); speed and turn rate also run the 100 step
// restoring divider, and each factor set takes 4 limb passes of the shared 32x32
// multiply-add. With a zero time delta only the distance job runs.
// s_tready is high only while the sequencer is idle; a finished result waits
// in the output register and the next sample is taken meanwhile.
// arst_n clears state, previous sample, tick sum and loads register defaults.
`timescale 1ns / 1ps

module diff_drive_odometry_unit #(
	parameter int unsigned SUM_WIDTH = 48
) (
	input  logic         clk,
	input  logic         arst_n,

	input  logic         s_tvalid,
	output logic         s_tready,
	// [31:0] right_count, [63:32] left_count, [95:64] time_ms
	input  logic [95:0]  s_tdata,

	output logic         m_tvalid,
	input  logic         m_tready,
	// [31:0] right_delta, [63:32] left_delta, [95:64] time_delta,
	// [127:96] distance, [159:128] speed, [191:160] turn_rate
	output logic [191:0] m_tdata,
	// [0] time_zero, [1] saturated
	output logic [1:0]   m_tuser,

	input  logic         cfg_we,
	input  logic         cfg_addr,
	input  logic [31:0]  cfg_wdata
);
	import ddo_pkg::*;

	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b00_0000_0001,
		ST_DELTA  = 10'b00_0000_0010,
		ST_SUM    = 10'b00_0000_0100,
		ST_ACC    = 10'b00_0000_1000,
		ST_LOAD   = 10'b00_0001_0000,
		ST_MUL    = 10'b00_0010_0000,
		ST_DIVPRE = 10'b00_0100_0000,
		ST_DIV    = 10'b00_1000_0000,
		ST_CLIP   = 10'b01_0000_0000,
		ST_DONE   = 10'b10_0000_0000
	} state_t;

	typedef enum logic [1:0] {
		JOB_DIST,
		JOB_SPEED,
		JOB_TURN
	} job_t;

	typedef enum logic [1:0] {
		MUL_DPT,
		MUL_IHB,
		MUL_MS
	} mul_sel_t;

	state_t state_q;

	logic [31:0]          dist_per_tick_q;
	logic [23:0]          inv_half_base_q;
	logic [31:0]          prev_right_q;
	logic [31:0]          prev_left_q;
	logic [31:0]          prev_time_q;
	logic [SUM_WIDTH-1:0] tick_sum_q;

	logic [31:0]          in_right_q;
	logic [31:0]          in_left_q;
	logic [31:0]          in_time_q;
	logic signed [31:0]   dr_q;
	logic signed [31:0]   dl_q;
	logic [31:0]          td_q;
	logic signed [33:0]   s_q;
	logic signed [33:0]   t_q;

	logic [ACC_LIMBS-1:0][LIMB_W-1:0] acc_q;
	logic [ACC_W-1:0]     acc_flat;
	logic [31:0]          carry_q;
	logic [1:0]           limb_q;
	mul_sel_t             mul_sel_q;
	job_t                 job_q;
	logic                 neg_q;
	logic [31:0]          rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	logic [31:0]          dist_q;
	logic [31:0]          speed_q;
	logic [31:0]          turn_q;
	logic                 sat_q;

	logic                 m_tvalid_q;
	logic [191:0]         m_data_q;
	logic [1:0]           m_user_q;

	logic                 td_zero;
	logic                 out_free;
	logic                 mul_last;
	logic                 ts_neg;
	logic [SUM_WIDTH-1:0] ts_mag;
	logic [SUM_WIDTH-1:0] ts_next;
	logic signed [63:0]   s_wide;
	logic [33:0]          s_mag;
	logic [33:0]          t_mag;
	logic [31:0]          mul_operand;
	logic                 div_ge;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;
	sat_req_t sat_req;
	sat_rsp_t sat_rsp;

	ddo_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	ddo_sat u_sat (
		.req (sat_req),
		.rsp (sat_rsp)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

	assign acc_flat = acc_q;
	assign td_zero  = (td_q == 32'd0);
	assign out_free = !m_tvalid_q || m_tready;
	assign mul_last = (mul_sel_q == MUL_MS) || (job_q == JOB_DIST);

	always_comb begin
		ts_neg  = tick_sum_q[SUM_WIDTH-1];
		ts_mag  = ts_neg ? (~tick_sum_q + 1'b1) : tick_sum_q;
		s_wide  = 64'(s_q);
		ts_next = tick_sum_q + s_wide[SUM_WIDTH-1:0];
		s_mag   = s_q[33] ? (~s_q + 34'd1) : s_q;
		t_mag   = t_q[33] ? (~t_q + 34'd1) : t_q;
	end

	always_comb begin
		case (mul_sel_q)
			MUL_DPT: mul_operand = dist_per_tick_q;
			MUL_IHB: mul_operand = {8'd0, inv_half_base_q};
			MUL_MS:  mul_operand = MS_PER_S;
			default: mul_operand = '0;
		endcase
	end

	// the divider reuses the adder path as a compare-subtract
	always_comb begin
		if (state_q == ST_DIV) begin
			alu_req.op = ALU_SUB;
			alu_req.a  = {rem_q, acc_flat[ACC_W-1]};
			alu_req.b  = td_q;
			alu_req.c  = '0;
		end else begin
			alu_req.op = ALU_MAC;
			alu_req.a  = {1'b0, acc_q[limb_q]};
			alu_req.b  = mul_operand;
			alu_req.c  = carry_q;
		end
		div_ge = !alu_rsp.res[63];
	end

	always_comb begin
		sat_req.acc         = acc_flat;
		sat_req.sh_long     = (job_q == JOB_TURN);
		sat_req.neg         = neg_q;
		sat_req.is_unsigned = (job_q == JOB_SPEED);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			dist_per_tick_q <= RST_DIST_PER_TICK;
			inv_half_base_q <= RST_INV_HALF_BASE;
			prev_right_q    <= '0;
			prev_left_q     <= '0;
			prev_time_q     <= '0;
			tick_sum_q      <= '0;
			m_tvalid_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					CFG_DIST_PER_TICK: dist_per_tick_q <= cfg_wdata;
					CFG_INV_HALF_BASE: inv_half_base_q <= cfg_wdata[23:0];
					default: ;
				endcase
			end
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_DELTA;
					end
				end
				ST_DELTA: begin
					prev_right_q <= in_right_q;
					prev_left_q  <= in_left_q;
					prev_time_q  <= in_time_q;
					state_q      <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					tick_sum_q <= ts_next;
					state_q    <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (limb_q == 2'd3 && mul_last) begin
						state_q <= (job_q == JOB_DIST) ? ST_CLIP : ST_DIVPRE;
					end
				end
				ST_DIVPRE: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_cnt_q == DIV_LAST) begin
						state_q <= ST_CLIP;
					end
				end
				ST_CLIP: begin
					if (job_q == JOB_TURN || (job_q == JOB_DIST && td_zero)) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					in_right_q <= s_tdata[31:0];
					in_left_q  <= s_tdata[63:32];
					in_time_q  <= s_tdata[95:64];
				end
			end
			ST_DELTA: begin
				dr_q    <= in_right_q - prev_right_q;
				dl_q    <= in_left_q - prev_left_q;
				td_q    <= in_time_q - prev_time_q;
				speed_q <= '0;
				turn_q  <= '0;
				sat_q   <= 1'b0;
				job_q   <= JOB_DIST;
			end
			ST_SUM: begin
				s_q <= 34'(dr_q) + 34'(dl_q);
				t_q <= 34'(dl_q) - 34'(dr_q);
			end
			ST_LOAD: begin
				mul_sel_q <= MUL_DPT;
				limb_q    <= '0;
				carry_q   <= '0;
				case (job_q)
					JOB_DIST: begin
						acc_q <= ACC_W'(ts_mag);
						neg_q <= ts_neg;
					end
					JOB_SPEED: begin
						acc_q <= ACC_W'(s_mag);
						neg_q <= 1'b0;
					end
					JOB_TURN: begin
						acc_q <= ACC_W'(t_mag);
						neg_q <= t_q[33];
					end
					default: begin
						acc_q <= '0;
						neg_q <= 1'b0;
					end
				endcase
			end
			ST_MUL: begin
				acc_q[limb_q] <= alu_rsp.res[31:0];
				carry_q       <= (limb_q == 2'd3) ? '0 : alu_rsp.res[63:32];
				limb_q        <= limb_q + 2'd1;
				if (limb_q == 2'd3) begin
					case (mul_sel_q)
						MUL_DPT: mul_sel_q <= (job_q == JOB_TURN) ? MUL_IHB : MUL_MS;
						MUL_IHB: mul_sel_q <= MUL_MS;
						default: mul_sel_q <= MUL_MS;
					endcase
				end
			end
			ST_DIVPRE: begin
				acc_q     <= acc_flat << DIV_PRESHIFT;
				rem_q     <= '0;
				div_cnt_q <= '0;
			end
			ST_DIV: begin
				// quotient bits shift in at the bottom as dividend bits leave the top
				acc_q     <= {acc_flat[ACC_W-2:0], div_ge};
				rem_q     <= div_ge ? alu_rsp.res[31:0] : {rem_q[30:0], acc_flat[ACC_W-1]};
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			ST_CLIP: begin
				sat_q <= sat_q | sat_rsp.over;
				case (job_q)
					JOB_DIST: begin
						dist_q <= sat_rsp.value;
						job_q  <= JOB_SPEED;
					end
					JOB_SPEED: begin
						speed_q <= sat_rsp.value;
						job_q   <= JOB_TURN;
					end
					JOB_TURN: turn_q <= sat_rsp.value;
					default: ;
				endcase
			end
			ST_DONE: begin
				if (out_free) begin
					m_data_q <= {turn_q, speed_q, dist_q, td_q, dl_q, dr_q};
					m_user_q <= {sat_q, td_zero};
				end
			end
			default: ;
		endcase
	end

endmodule

@@ design/ddo_alu.sv @@
`timescale 1ns / 1ps

module ddo_alu (
	input  ddo_pkg::alu_req_t req,
	output ddo_pkg::alu_rsp_t rsp
);
	import ddo_pkg::*;

	always_comb begin
		case (req.op)
			ALU_MAC: rsp.res = 64'(req.a[31:0]) * 64'(req.b) + 64'(req.c);
			ALU_SUB: rsp.res = 64'(req.a) - 64'(req.b);
			default: rsp.res = '0;
		endcase
	end

endmodule

@@ design/ddo_sat.sv @@
`timescale 1ns / 1ps

module ddo_sat (
	input  ddo_pkg::sat_req_t req,
	output ddo_pkg::sat_rsp_t rsp
);
	import ddo_pkg::*;

	logic [ACC_W-1:0] shifted;
	logic [31:0]      limit;
	logic [31:0]      mag;

	always_comb begin
		shifted = req.sh_long ? (req.acc >> 33) : (req.acc >> 17);
		if (req.is_unsigned) begin
			limit = 32'hFFFF_FFFF;
		end else if (req.neg) begin
			limit = 32'h8000_0000;
		end else begin
			limit = 32'h7FFF_FFFF;
		end
		rsp.over  = (|shifted[ACC_W-1:32]) || (shifted[31:0] > limit);
		mag       = rsp.over ? limit : shifted[31:0];
		rsp.value = req.neg ? (~mag + 32'd1) : mag;
	end

endmodule

@@ design/ddo_checker.sv @@
`timescale 1ns / 1ps

module ddo_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [191:0] m_tdata,
	input logic [1:0]   m_tuser
);

	// a stalled result holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	else $error("stalled result changed");

	// one sample at a time: busy right after a transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
	else $error("input taken while sample in flight");

	// zero time delta forces zero speed and turn rate
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[191:128] == 64'd0)
	else $error("nonzero rate with zero time delta");

	// time_zero flag matches the time delta field
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[95:64] == 32'd0) == m_tuser[0]))
	else $error("time_zero flag mismatch");

endmodule

bind diff_drive_odometry_unit ddo_checker u_ddo_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tuser   (m_tuser)
);
